// ===== rtl/core/gpks_pkg.sv =====
// ----------------------------------------------------------------------------
// GNSS position smoother package
// Field widths and configuration register indexes shared by the channel
// interfaces and the smoother core.
// ----------------------------------------------------------------------------
package gpks_pkg;

  // Payload field widths.
  localparam int unsigned LAT_W     = 31;
  localparam int unsigned LON_W     = 32;
  localparam int unsigned NOISE_W   = 48;
  localparam int unsigned CFG_IDX_W = 1;

  // Width of one multiplier digit in the shared multiply unit.
  localparam int unsigned MUL_CHUNK_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

  // Register values after reset.
  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 48'd2814750;
  localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 48'd2814749767;

endpackage

// ===== rtl/core/gpks_if.sv =====
// ----------------------------------------------------------------------------
// GNSS position smoother channel interfaces
// Valid/ready channels for fixes, smoothed results and register writes.
// ----------------------------------------------------------------------------
interface gpks_fix_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gpks_pkg::LAT_W-1:0]    fix_latitude;
  logic signed [gpks_pkg::LON_W-1:0]    fix_longitude;
  logic                                 fix_valid;
  logic                                 restart;

  modport source (output valid, fix_latitude, fix_longitude, fix_valid, restart,
                  input ready);
  modport sink (input valid, fix_latitude, fix_longitude, fix_valid, restart,
                output ready);
endinterface

interface gpks_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gpks_pkg::LAT_W-1:0]    smoothed_latitude;
  logic signed [gpks_pkg::LON_W-1:0]    smoothed_longitude;
  logic                                 first_after_restart;

  modport source (output valid, smoothed_latitude, smoothed_longitude,
                  first_after_restart, input ready);
  modport sink (input valid, smoothed_latitude, smoothed_longitude,
                first_after_restart, output ready);
endinterface

interface gpks_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [gpks_pkg::CFG_IDX_W-1:0]       reg_index;
  logic [gpks_pkg::NOISE_W-1:0]         wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/core/gnss_position_kalman_smoother.sv =====
// ----------------------------------------------------------------------------
// GNSS position Kalman smoother
// Scalar Kalman filter over latitude and longitude with one shared variance.
// ----------------------------------------------------------------------------
// Usage:
//   fix_i takes one GNSS fix per transfer; res_o gives at most one smoothed
//   position per fix; cfg_i writes the process noise (index 0) and the
//   measurement noise (index 1) and is always ready. Write it only while idle.
//   An invalid fix gives no result. The first valid fix after reset or after a
//   restart loads the estimates unfiltered and sets the variance to 1.0.
// Timing:
//   fix_i is ready only in the idle state. An invalid fix leaves the core idle;
//   an initializing fix goes straight to the finish state, which registers its
//   result. A filtered fix runs two updates, latitude then longitude, each
//   through prepare, divide, gain multiply, apply and variance multiply.
//   A zero denominator skips the divide steps of its update. The gain comes
//   from a restoring divider; the multiplier works in 16-bit digits.
// Reset and stall:
//   Reset clears the estimates and the result valid flag, sets the variance to
//   1.0 and loads the noise registers with their defaults. A result waits in
//   its output register while res_o is stalled; the core holds the next
//   finished result until that register frees up.
// ----------------------------------------------------------------------------
module gnss_position_kalman_smoother #(
  parameter int unsigned VARIANCE_FRAC_BITS = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  gpks_fix_if.sink       fix_i,
  gpks_res_if.source     res_o,
  gpks_cfg_if.sink       cfg_i
);

  localparam int unsigned F   = VARIANCE_FRAC_BITS;
  localparam int unsigned VW  = F + 1;
  localparam int unsigned NW  = gpks_pkg::NOISE_W;
  localparam int unsigned SW  = ((VW > NW) ? VW : NW) + 1;
  localparam int unsigned RW  = SW + 1;
  localparam int unsigned CW  = gpks_pkg::MUL_CHUNK_W;
  localparam int unsigned NCH = (VW + CW - 1) / CW;
  localparam int unsigned MW  = NCH * CW;
  localparam int unsigned PW  = VW + MW;
  localparam int unsigned DCW = $clog2(F);
  localparam int unsigned MCW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned LTW = gpks_pkg::LAT_W;
  localparam int unsigned LNW = gpks_pkg::LON_W;

  localparam logic [VW-1:0] VAR_MAX = '1;
  localparam logic [VW-1:0] ONE     = {1'b1, {F{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_INIT,
    ST_DIV,
    ST_GAIN,
    ST_MUL_GAIN,
    ST_APPLY,
    ST_MUL_VAR,
    ST_VAR_UPD,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic                    axis_q;
  logic                    primed_q;
  logic [VW-1:0]           var_q;
  logic [LTW-1:0]          est_lat_q;
  logic [LNW-1:0]          est_lon_q;
  logic [NW-1:0]           pnoise_q;
  logic [NW-1:0]           mnoise_q;
  logic                    out_valid_q;
  logic                    first_q;

  // Datapath registers.
  logic signed [LNW-1:0]   e_q;
  logic signed [LNW-1:0]   m_q;
  logic [LNW-1:0]          lon_meas_q;
  logic [VW-1:0]           v_q;
  logic [SW-1:0]           d_q;
  logic [RW-1:0]           rem_q;
  logic [VW-1:0]           gain_q;
  logic [DCW-1:0]          dcnt_q;
  logic                    neg_q;
  logic [VW-1:0]           ma_q;
  logic [MW-1:0]           mb_q;
  logic [PW-1:0]           acc_q;
  logic [MCW-1:0]          mcnt_q;
  logic [LTW-1:0]          res_lat_q;
  logic [LNW-1:0]          res_lon_q;
  logic                    res_first_q;

  logic                    fix_xfer;
  logic                    res_xfer;
  logic                    out_free;
  logic [SW-1:0]           v_sum;
  logic [VW-1:0]           v_sat;
  logic [SW-1:0]           d_sum;
  logic [RW-1:0]           rem_sh;
  logic                    rem_ge;
  logic [RW-1:0]           rem_nxt;
  logic [LNW:0]            diff;
  logic [LNW:0]            mag;
  logic [VW+CW-1:0]        pp;
  logic [PW-1:0]           acc_nxt;
  logic [LNW-1:0]          delta;
  logic [LNW:0]            e_new;

  assign fix_xfer = fix_i.valid && fix_i.ready;
  assign res_xfer = res_o.valid && res_o.ready;
  assign out_free = !out_valid_q || res_o.ready;

  assign fix_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid               = out_valid_q;
  assign res_o.smoothed_latitude   = res_lat_q;
  assign res_o.smoothed_longitude  = res_lon_q;
  assign res_o.first_after_restart = res_first_q;

  // Variance grows by the process noise and saturates at its field maximum.
  assign v_sum = SW'(var_q) + SW'(pnoise_q);
  assign v_sat = (v_sum > SW'(VAR_MAX)) ? VAR_MAX : v_sum[VW-1:0];
  assign d_sum = SW'(v_sat) + SW'(mnoise_q);

  // One restoring division step per cycle.
  assign rem_sh  = {rem_q[RW-2:0], 1'b0};
  assign rem_ge  = (rem_sh >= RW'(d_q));
  assign rem_nxt = rem_ge ? (rem_sh - RW'(d_q)) : rem_sh;

  assign diff = {m_q[LNW-1], m_q} - {e_q[LNW-1], e_q};
  assign mag  = diff[LNW] ? (~diff + 1'b1) : diff;

  // Multiply one 16-bit digit of the multiplier per cycle, most significant first.
  assign pp      = ma_q * mb_q[MW-1 -: CW];
  assign acc_nxt = {acc_q[PW-CW-1:0], {CW{1'b0}}} + PW'(pp);

  assign delta = acc_q[F +: LNW];
  assign e_new = neg_q ? ({e_q[LNW-1], e_q} - {1'b0, delta})
                       : ({e_q[LNW-1], e_q} + {1'b0, delta});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      primed_q    <= 1'b0;
      var_q       <= ONE;
      est_lat_q   <= '0;
      est_lon_q   <= '0;
      pnoise_q    <= gpks_pkg::PROCESS_NOISE_RST;
      mnoise_q    <= gpks_pkg::MEASUREMENT_NOISE_RST;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.reg_index)
          gpks_pkg::CFG_PROCESS_NOISE:     pnoise_q <= cfg_i.wr_data;
          gpks_pkg::CFG_MEASUREMENT_NOISE: mnoise_q <= cfg_i.wr_data;
          default: ;
        endcase
      end
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (fix_xfer) begin
            axis_q <= 1'b0;
            if (fix_i.fix_valid) begin
              // A restart in the same transfer makes this the initializing fix.
              if (!primed_q || fix_i.restart) begin
                est_lat_q <= fix_i.fix_latitude;
                est_lon_q <= fix_i.fix_longitude;
                var_q     <= ONE;
                primed_q  <= 1'b1;
                first_q   <= 1'b1;
                state_q   <= ST_FINISH;
              end else begin
                first_q <= 1'b0;
                state_q <= ST_PREP;
              end
            end else if (fix_i.restart) begin
              primed_q <= 1'b0;
            end
          end
        end
        ST_PREP: begin
          state_q <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          // A zero denominator skips the division and leaves the gain at one LSB.
          state_q <= (d_q == '0) ? ST_GAIN : ST_DIV;
        end
        ST_DIV: begin
          if (dcnt_q == DCW'(F - 1)) begin
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          state_q <= ST_MUL_GAIN;
        end
        ST_MUL_GAIN: begin
          if (mcnt_q == '0) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (axis_q) begin
            est_lon_q <= e_new[LNW-1:0];
          end else begin
            est_lat_q <= e_new[LTW-1:0];
          end
          state_q <= ST_MUL_VAR;
        end
        ST_MUL_VAR: begin
          if (mcnt_q == '0) begin
            state_q <= ST_VAR_UPD;
          end
        end
        ST_VAR_UPD: begin
          var_q <= acc_q[F +: VW];
          if (axis_q) begin
            state_q <= ST_FINISH;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_PREP;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        e_q        <= {est_lat_q[LTW-1], est_lat_q};
        m_q        <= {fix_i.fix_latitude[LTW-1], fix_i.fix_latitude};
        lon_meas_q <= fix_i.fix_longitude;
      end
      ST_PREP: begin
        v_q <= v_sat;
        d_q <= d_sum;
      end
      ST_DIV_INIT: begin
        dcnt_q <= '0;
        if (SW'(v_q) >= d_q) begin
          gain_q <= VW'(1);
          rem_q  <= RW'(SW'(v_q) - d_q);
        end else begin
          gain_q <= '0;
          rem_q  <= RW'(v_q);
        end
      end
      ST_DIV: begin
        rem_q  <= rem_nxt;
        gain_q <= {gain_q[VW-2:0], rem_ge};
        dcnt_q <= dcnt_q + 1'b1;
      end
      ST_GAIN: begin
        neg_q  <= diff[LNW];
        ma_q   <= VW'(mag[LNW-1:0]);
        mb_q   <= MW'(gain_q);
        acc_q  <= '0;
        mcnt_q <= MCW'(NCH - 1);
      end
      ST_MUL_GAIN, ST_MUL_VAR: begin
        acc_q  <= acc_nxt;
        mb_q   <= mb_q << CW;
        mcnt_q <= mcnt_q - 1'b1;
      end
      ST_APPLY: begin
        ma_q   <= v_q;
        mb_q   <= MW'(ONE - gain_q);
        acc_q  <= '0;
        mcnt_q <= MCW'(NCH - 1);
      end
      ST_VAR_UPD: begin
        e_q <= est_lon_q;
        m_q <= lon_meas_q;
      end
      ST_FINISH: begin
        if (out_free) begin
          res_lat_q   <= est_lat_q;
          res_lon_q   <= est_lon_q;
          res_first_q <= first_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GAIN |-> gain_q <= ONE)
    else $error("gain above one");

  a_delta_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_APPLY |-> VW'(delta) <= ma_q)
    else $error("estimate step larger than the innovation");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ready |=> res_o.valid && $stable(res_o.smoothed_latitude)
      && $stable(res_o.smoothed_longitude) && $stable(res_o.first_after_restart))
    else $error("stalled result changed or dropped");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside the finish state");
`endif

endmodule

// ===== sim/gnss_position_kalman_smoother_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GNSS position smoother testbench
// Sends directed and random fixes through the smoother under several noise
// settings and idle patterns. A scoreboard class keeps its own copy of the
// filter state, predicts every smoothed position and checks each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module gnss_position_kalman_smoother_tb;

  localparam int unsigned LAT_W     = gpks_pkg::LAT_W;
  localparam int unsigned LON_W     = gpks_pkg::LON_W;
  localparam int unsigned NOISE_W   = gpks_pkg::NOISE_W;
  localparam int unsigned CFG_IDX_W = gpks_pkg::CFG_IDX_W;

  localparam int unsigned FRAC          = 48;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned CYCLE_LIMIT   = 1500000;
  localparam int unsigned SEGMENTS      = 6;
  localparam int unsigned SEGMENT_ITEMS = 200;
  localparam int unsigned REPORT_MAX    = 10;

  localparam logic [63:0]        VAR_ONE   = 64'd1 << FRAC;
  localparam logic [63:0]        VAR_MAX   = (64'd1 << (FRAC + 1)) - 64'd1;
  localparam logic [NOISE_W-1:0] NOISE_MAX = '1;

  localparam logic signed [LAT_W-1:0] LAT_MAX_BITS = 31'sh3FFFFFFF;
  localparam logic signed [LAT_W-1:0] LAT_MIN_BITS = 31'sh40000000;
  localparam logic signed [LON_W-1:0] LON_MAX_BITS = 32'sh7FFFFFFF;
  localparam logic signed [LON_W-1:0] LON_MIN_BITS = 32'sh80000000;

  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
    logic             first;
  } smoothed_fix_t;

  class position_scoreboard;
    logic [63:0]   proc_noise;
    logic [63:0]   meas_noise;
    logic [63:0]   variance;
    longint        est_lat;
    longint        est_lon;
    bit            primed;
    smoothed_fix_t expected_q[$];
    int unsigned   fail_count;

    function new();
      proc_noise = 64'(gpks_pkg::PROCESS_NOISE_RST);
      meas_noise = 64'(gpks_pkg::MEASUREMENT_NOISE_RST);
      variance   = VAR_ONE;
      est_lat    = 0;
      est_lon    = 0;
      primed     = 1'b0;
      fail_count = 0;
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%s", msg);
    endfunction

    function void set_noise(logic [CFG_IDX_W-1:0] idx, logic [NOISE_W-1:0] value);
      if (idx == gpks_pkg::CFG_PROCESS_NOISE) proc_noise = 64'(value);
      else meas_noise = 64'(value);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One scalar update; both coordinates share and change the one variance.
    function longint filter_step(longint est, longint meas);
      logic [63:0]  v;
      logic [63:0]  denom;
      logic [63:0]  gain;
      logic [63:0]  mag;
      logic [63:0]  delta;
      logic [127:0] prod;
      longint       diff;
      v = variance + proc_noise;
      if (v > VAR_MAX) v = VAR_MAX;
      denom = v + meas_noise;
      if (denom == 64'd0) gain = 64'd0;
      else gain = 64'(({64'd0, v} << FRAC) / {64'd0, denom});
      diff = meas - est;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      prod = {64'd0, mag} * {64'd0, gain};
      delta = 64'(prod >> FRAC);
      if (diff < 0) est = est - longint'(delta);
      else est = est + longint'(delta);
      prod = {64'd0, v} * {64'd0, VAR_ONE - gain};
      variance = 64'(prod >> FRAC);
      if (variance > VAR_MAX) variance = VAR_MAX;
      return est;
    endfunction

    function void note_fix(logic signed [LAT_W-1:0] lat, logic signed [LON_W-1:0] lon,
                           logic fix_ok, logic restart);
      smoothed_fix_t pos;
      if (restart) primed = 1'b0;
      if (!fix_ok) return;
      if (!primed) begin
        est_lat   = lat;
        est_lon   = lon;
        variance  = VAR_ONE;
        primed    = 1'b1;
        pos.first = 1'b1;
      end else begin
        est_lat   = filter_step(est_lat, lat);
        est_lon   = filter_step(est_lon, lon);
        pos.first = 1'b0;
      end
      pos.lat = est_lat[LAT_W-1:0];
      pos.lon = est_lon[LON_W-1:0];
      expected_q.push_back(pos);
    endfunction

    function void check_result(smoothed_fix_t got);
      smoothed_fix_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result: lat %0d lon %0d first %0b",
                         $signed(got.lat), $signed(got.lon), got.first));
        return;
      end
      want = expected_q.pop_front();
      if (got.lat !== want.lat || got.lon !== want.lon || got.first !== want.first)
        report($sformatf("mismatch: lat exp %0d got %0d, lon exp %0d got %0d, first exp %0b got %0b",
                         $signed(want.lat), $signed(got.lat), $signed(want.lon),
                         $signed(got.lon), want.first, got.first));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  gpks_fix_if fix_bus ();
  gpks_res_if res_bus ();
  gpks_cfg_if cfg_bus ();

  gnss_position_kalman_smoother #(
    .VARIANCE_FRAC_BITS(FRAC)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fix_i (fix_bus),
    .res_o (res_bus),
    .cfg_i (cfg_bus)
  );

  position_scoreboard sb;
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  longint             track_lat;
  longint             track_lon;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Holds valid high after a transfer, so back-to-back fixes need no re-raise.
  task automatic send_fix(input logic signed [LAT_W-1:0] lat,
                          input logic signed [LON_W-1:0] lon,
                          input logic fix_ok, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      fix_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    fix_bus.valid         <= 1'b1;
    fix_bus.fix_latitude  <= lat;
    fix_bus.fix_longitude <= lon;
    fix_bus.fix_valid     <= fix_ok;
    fix_bus.restart       <= restart;
    do @(posedge clk_i); while (fix_bus.ready !== 1'b1);
    sb.note_fix(lat, lon, fix_ok, restart);
  endtask

  task automatic write_noise(input logic [NOISE_W-1:0] q, input logic [NOISE_W-1:0] r);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= gpks_pkg::CFG_PROCESS_NOISE;
    cfg_bus.wr_data   <= q;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    sb.set_noise(gpks_pkg::CFG_PROCESS_NOISE, q);
    cfg_bus.reg_index <= gpks_pkg::CFG_MEASUREMENT_NOISE;
    cfg_bus.wr_data   <= r;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    sb.set_noise(gpks_pkg::CFG_MEASUREMENT_NOISE, r);
    cfg_bus.valid <= 1'b0;
  endtask

  // An invalid fix gives no result and leaves the core in its idle state; the
  // settle time runs after the last expected result.
  task automatic wait_idle();
    fix_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic longint clamp_coord(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // Mostly a noisy track with occasional jumps, dropouts and restarts; a few
  // fixes carry arbitrary bit patterns.
  task automatic random_fix();
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    if ($urandom_range(99) < 8) begin
      lat = LAT_W'($urandom);
      lon = LON_W'($urandom);
    end else begin
      if ($urandom_range(99) < 3) begin
        track_lat = longint'($urandom_range(32'd1800000000, 0)) - 900000000;
        track_lon = longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
      end
      track_lat = clamp_coord(track_lat + longint'($urandom_range(4000, 0)) - 2000,
                              900000000);
      track_lon = clamp_coord(track_lon + longint'($urandom_range(4000, 0)) - 2000,
                              1800000000);
      lat = LAT_W'(clamp_coord(track_lat + longint'($urandom_range(1000, 0)) - 500,
                               900000000));
      lon = LON_W'(clamp_coord(track_lon + longint'($urandom_range(1000, 0)) - 500,
                               1800000000));
    end
    send_fix(lat, lon, $urandom_range(99) >= 12, $urandom_range(99) < 4);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready)
      sb.check_result('{res_bus.smoothed_latitude, res_bus.smoothed_longitude,
                        res_bus.first_after_restart});
    res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [NOISE_W-1:0] q;
    logic [NOISE_W-1:0] r;
    sb = new();
    rst_ni                = 1'b0;
    fix_bus.valid         = 1'b0;
    fix_bus.fix_latitude  = '0;
    fix_bus.fix_longitude = '0;
    fix_bus.fix_valid     = 1'b0;
    fix_bus.restart       = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.reg_index     = gpks_pkg::CFG_PROCESS_NOISE;
    cfg_bus.wr_data       = '0;
    send_idle_pct         = 6;
    recv_idle_pct         = 54;
    track_lat             = 0;
    track_lon             = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The first valid fix after reset initializes although no restart came.
    send_fix(0, 0, 1'b1, 1'b0);
    send_fix(900000000, 1800000000, 1'b1, 1'b0);
    send_fix(-900000000, -1800000000, 1'b1, 1'b0);
    send_fix(123456, -654321, 1'b0, 1'b0);
    // A restart on an invalid fix leaves the filter unprimed until a valid one.
    send_fix(0, 0, 1'b0, 1'b1);
    send_fix(-1, -1, 1'b0, 1'b0);
    send_fix(450000000, -900000000, 1'b1, 1'b0);
    send_fix(LAT_MAX_BITS, LON_MAX_BITS, 1'b1, 1'b0);
    send_fix(LAT_MIN_BITS, LON_MIN_BITS, 1'b1, 1'b0);
    // Restart and a valid fix in the same transfer: this fix initializes.
    send_fix(LAT_MIN_BITS, LON_MIN_BITS, 1'b1, 1'b1);
    send_fix(LAT_MAX_BITS, LON_MAX_BITS, 1'b1, 1'b0);
    send_fix(LAT_MAX_BITS, LON_MAX_BITS, 1'b1, 1'b0);
    send_fix(0, 0, 1'b1, 1'b1);
    send_fix(1, -1, 1'b1, 1'b0);
    repeat (8) random_fix();

    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      wait_idle();
      case (seg)
        0: begin
          // Zero noise drives the variance to zero, then the denominator too.
          q = '0;
          r = '0;
        end
        1: begin
          q = NOISE_MAX;
          r = NOISE_MAX;
        end
        2: begin
          q = NOISE_MAX;
          r = '0;
        end
        3: begin
          q = NOISE_W'({$urandom, $urandom}) >> $urandom_range(NOISE_W - 1, 0);
          r = NOISE_W'({$urandom, $urandom}) >> $urandom_range(NOISE_W - 1, 0);
        end
        4: begin
          q = '0;
          r = NOISE_MAX;
        end
        default: begin
          q = gpks_pkg::PROCESS_NOISE_RST;
          r = gpks_pkg::MEASUREMENT_NOISE_RST;
        end
      endcase
      write_noise(q, r);
      case (seg / 2)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (SEGMENT_ITEMS) random_fix();
    end

    wait_idle();
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
